// ----- rtl/ir_pulse_distance_decoder_top_assert.svh -----
// Assertion helpers shared by the decoder RTL.
// Both expect clk and arst_n in the enclosing scope.
`ifndef IR_PULSE_DISTANCE_DECODER_TOP_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define IRPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/irpd_pkg.sv -----
package irpd_pkg;

	localparam int CODE_BITS_DEF = 32;
	localparam int CODE_W        = 32;
	localparam int DUR_W         = 16;
	localparam int TOL_W         = 7;
	localparam int NOM_W         = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 32;
	localparam int PCT_SCALE     = 100;
	localparam int WIN_W         = 24;

	localparam logic [NOM_W-1:0] HDR_MARK_US    = NOM_W'(4500);
	localparam logic [NOM_W-1:0] HDR_SPACE_US   = NOM_W'(4500);
	localparam logic [NOM_W-1:0] BIT_MARK_US    = NOM_W'(560);
	localparam logic [NOM_W-1:0] ONE_SPACE_US   = NOM_W'(1690);
	localparam logic [NOM_W-1:0] ZERO_SPACE_US  = NOM_W'(560);
	localparam logic [NOM_W-1:0] FOOTER_MARK_US = NOM_W'(560);

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(25);

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED  = CFG_IDX_W'(1);

	typedef struct packed {
		logic [DUR_W-1:0] duration_us;
		logic             is_mark;
		logic             frame_first;
	} item_t;

	typedef struct packed {
		logic              frame_ok;
		logic [CODE_W-1:0] decoded_code;
		logic              code_match;
	} result_t;

	typedef struct packed {
		logic [TOL_W-1:0]  tolerance_pct;
		logic [CODE_W-1:0] expected_code;
	} cfg_t;

	typedef struct packed {
		logic    emit;
		result_t res;
	} dec_t;

	// floor(n*(100-t)/100) <= d <= floor(n*(100+t)/100), done without a divide:
	// d >= floor(x/100) <=> 100*d + 99 >= x, and d <= floor(x/100) <=> 100*d <= x.
	function automatic logic in_window(input logic [DUR_W-1:0] d,
			input logic [NOM_W-1:0] nom, input logic [TOL_W-1:0] tol);
		logic [WIN_W-1:0] d_scaled;
		logic [WIN_W-1:0] hi_lim;
		logic [WIN_W-1:0] lo_lim;
		logic             lo_ok;
		d_scaled = WIN_W'(d) * WIN_W'(PCT_SCALE);
		hi_lim   = WIN_W'(nom) * (WIN_W'(PCT_SCALE) + WIN_W'(tol));
		lo_lim   = (tol >= TOL_W'(PCT_SCALE)) ? '0
			: WIN_W'(nom) * (WIN_W'(PCT_SCALE) - WIN_W'(tol));
		lo_ok    = (d_scaled + WIN_W'(PCT_SCALE - 1)) >= lo_lim;
		return lo_ok && (d_scaled <= hi_lim);
	endfunction

endpackage

// ----- rtl/irpd_if.sv -----
interface irpd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] duration_us;
	logic        is_mark;
	logic        frame_first;

	modport source (output valid, output duration_us, output is_mark, output frame_first,
		input ready);
	modport sink (input valid, input duration_us, input is_mark, input frame_first,
		output ready);
endinterface

interface irpd_out_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [31:0] decoded_code;
	logic        code_match;

	modport source (output valid, output frame_ok, output decoded_code, output code_match,
		input ready);
	modport sink (input valid, input frame_ok, input decoded_code, input code_match,
		output ready);
endinterface

// ----- rtl/irpd_frame_fsm.sv -----
`include "ir_pulse_distance_decoder_top_assert.svh"

module irpd_frame_fsm #(
	parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  irpd_pkg::cfg_t  cfg,
	input  logic           step_valid,
	input  irpd_pkg::item_t step_item,
	output irpd_pkg::dec_t  dec
);
	import irpd_pkg::*;

	localparam int CNT_W = $clog2(CODE_BITS + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR_MARK,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE
	} phase_t;

	phase_t             phase_q, phase_d, phase_eff;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_eff;
	logic [CODE_W-1:0]  shift_q, shift_d, shift_eff;
	logic               win_hdr, win_short, win_one;
	logic               emit, ok;

	assign win_hdr   = in_window(step_item.duration_us, HDR_MARK_US, cfg.tolerance_pct);
	// bit mark, zero space and footer share the 560 us nominal
	assign win_short = in_window(step_item.duration_us, BIT_MARK_US, cfg.tolerance_pct);
	assign win_one   = in_window(step_item.duration_us, ONE_SPACE_US, cfg.tolerance_pct);

	always_comb begin
		phase_eff = step_item.frame_first ? PH_HDR_MARK : phase_q;
		cnt_eff   = step_item.frame_first ? '0 : cnt_q;
		shift_eff = step_item.frame_first ? '0 : shift_q;
		phase_d   = phase_eff;
		cnt_d     = cnt_eff;
		shift_d   = shift_eff;
		emit      = 1'b0;
		ok        = 1'b0;
		case (phase_eff)
			PH_HDR_MARK: begin
				if (!step_item.is_mark || !win_hdr) begin
					emit = 1'b1;
				end else begin
					phase_d = PH_HDR_SPACE;
				end
			end
			PH_HDR_SPACE: begin
				if (step_item.is_mark || !win_hdr) begin
					emit = 1'b1;
				end else begin
					shift_d = '0;
					cnt_d   = '0;
					phase_d = PH_BIT_MARK;
				end
			end
			PH_BIT_MARK: begin
				if (cnt_eff >= CNT_W'(CODE_BITS)) begin
					// footer
					emit = 1'b1;
					ok   = step_item.is_mark && win_short;
				end else if (!step_item.is_mark || !win_short) begin
					emit = 1'b1;
				end else begin
					phase_d = PH_BIT_SPACE;
				end
			end
			PH_BIT_SPACE: begin
				if (step_item.is_mark) begin
					emit = 1'b1;
				end else if (win_one) begin
					// one wins where the windows overlap
					shift_d = {shift_eff[CODE_W-2:0], 1'b1};
					cnt_d   = cnt_eff + CNT_W'(1);
					phase_d = PH_BIT_MARK;
				end else if (win_short) begin
					shift_d = {shift_eff[CODE_W-2:0], 1'b0};
					cnt_d   = cnt_eff + CNT_W'(1);
					phase_d = PH_BIT_MARK;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	assign dec.emit             = emit;
	assign dec.res.frame_ok     = ok;
	assign dec.res.decoded_code = shift_eff;
	assign dec.res.code_match   = ok && (shift_eff == cfg.expected_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
		end else if (step_valid) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
		end
	end

	`IRPD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(CODE_BITS),
		"bit count past code length")
	`IRPD_ASSERT_NOW(a_hdr_cnt_zero, phase_q == PH_HDR_MARK || phase_q == PH_HDR_SPACE,
		cnt_q == '0, "bit count nonzero during header")
	`IRPD_ASSERT_NOW(a_match_needs_ok, step_valid && dec.emit && dec.res.code_match,
		dec.res.frame_ok, "code match on a failed frame")
	`IRPD_ASSERT_NEXT(a_first_to_hdr, step_valid && step_item.frame_first && !dec.emit,
		phase_q == PH_HDR_SPACE, "frame start did not enter header space")

endmodule

// ----- rtl/ir_pulse_distance_decoder_top.sv -----
// Pulse-distance IR remote decoder (4500/4500 header, CODE_BITS data bits MSB first with a
// 560 us mark and a 1690/560 us space, 560 us footer mark). One duration item is accepted
// every clock cycle while the output is not stalled; each item goes through an input register,
// a single decode step that compares it against the tolerance windows and updates the frame
// state, and a result register for the item that completes or breaks a frame. Items that
// only advance a frame give no result. frame_first restarts the frame at any time.
// Configuration writes take effect on the next cycle and belong between frames.
module ir_pulse_distance_decoder_top #(
	parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	irpd_in_if.sink                             in_item,
	irpd_out_if.source                          out_item,
	input  logic                                cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import irpd_pkg::*;

	cfg_t    cfg_q;
	logic    v_s1;
	item_t   item_s1;
	logic    out_v_q;
	result_t res_q;
	logic    adv;
	logic    in_acc;
	dec_t    dec;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance_pct <= TOL_RESET;
			cfg_q.expected_code <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOLERANCE: cfg_q.tolerance_pct <= cfg_wdata[TOL_W-1:0];
				CFG_EXPECTED:  cfg_q.expected_code <= cfg_wdata[CODE_W-1:0];
				default:       ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign adv           = v_s1 && (!out_v_q || out_item.ready);
	assign in_item.ready = !v_s1 || adv;
	assign in_acc        = in_item.valid && in_item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.duration_us <= in_item.duration_us;
			item_s1.is_mark     <= in_item.is_mark;
			item_s1.frame_first <= in_item.frame_first;
		end
	end

	irpd_frame_fsm #(
		.CODE_BITS(CODE_BITS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step_valid(adv),
		.step_item (item_s1),
		.dec       (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dec.emit;
		end else if (out_item.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dec.emit) begin
			res_q <= dec.res;
		end
	end

	assign out_item.valid        = out_v_q;
	assign out_item.frame_ok     = res_q.frame_ok;
	assign out_item.decoded_code = res_q.decoded_code;
	assign out_item.code_match   = res_q.code_match;

endmodule
